FILE: rtl/tba_pkg.sv
// ----------------------------------------------------------------------------
// tba_pkg: shared types and constants for the two-body acceleration pipeline
// Field widths, the gravity parameter reset value and the stage payload type.
// ----------------------------------------------------------------------------
package tba_pkg;

    localparam int COMP_W   = 32;
    localparam int GP_W     = 50;
    localparam int SUMSQ_W  = 64;
    localparam int ROOT_W   = 32;
    localparam int DEN_W    = 96;
    localparam logic [GP_W-1:0] GP_RESET = 50'd398717000000000;

    typedef struct packed {
        logic [COMP_W-1:0] vel_x;
        logic [COMP_W-1:0] vel_y;
        logic [COMP_W-1:0] vel_z;
        logic [2:0]        neg;
        logic              zero;
    } tba_side_t;

endpackage

FILE: rtl/tba_sqrt_stage.sv
// ----------------------------------------------------------------------------
// tba_sqrt_stage: one pipelined step of the floored integer square root
// Handles two result bits per stage (two restoring steps on the remainder).
// ----------------------------------------------------------------------------
module tba_sqrt_stage
    import tba_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic [SUMSQ_W-1:0] rem_in,
    input  logic [ROOT_W-1:0]  root_in,
    output logic [SUMSQ_W-1:0] rem_out,
    output logic [ROOT_W-1:0]  root_out
);

    // Digit-by-digit method, result bit position k = 31 - 2*STEP and next.
    localparam int K0 = ROOT_W - 1 - 2 * STEP;
    localparam int K1 = K0 - 1;

    logic [SUMSQ_W+1:0] trial0;
    logic [SUMSQ_W+1:0] trial1;
    logic [SUMSQ_W-1:0] rem_mid;
    logic [ROOT_W-1:0]  root_mid;

    always_comb
    begin
        // trial = (2*root*2^k + 2^(2k)) with root holding bits above k
        trial0 = ({34'd0, root_in} << (K0 + 1)) | ((SUMSQ_W + 2)'(1) << (2 * K0));
        if ({2'b00, rem_in} >= trial0)
        begin
            rem_mid  = rem_in - trial0[SUMSQ_W-1:0];
            root_mid = root_in | (ROOT_W'(1) << K0);
        end
        else
        begin
            rem_mid  = rem_in;
            root_mid = root_in;
        end
        trial1 = ({34'd0, root_mid} << (K1 + 1)) | ((SUMSQ_W + 2)'(1) << (2 * K1));
        if ({2'b00, rem_mid} >= trial1)
        begin
            rem_out  = rem_mid - trial1[SUMSQ_W-1:0];
            root_out = root_mid | (ROOT_W'(1) << K1);
        end
        else
        begin
            rem_out  = rem_mid;
            root_out = root_mid;
        end
    end

endmodule

FILE: rtl/tba_div_stage.sv
// ----------------------------------------------------------------------------
// tba_div_stage: one restoring division step for one axis
// Shifts the partial remainder in by one numerator bit and subtracts.
// ----------------------------------------------------------------------------
module tba_div_stage
    import tba_pkg::*;
(
    input  logic [DEN_W:0]     rem_in,
    input  logic               num_bit,
    input  logic [DEN_W-1:0]   den,
    output logic [DEN_W:0]     rem_out,
    output logic               q_bit
);

    logic [DEN_W+1:0] shifted;

    always_comb
    begin
        shifted = {rem_in, num_bit};
        if (shifted >= {2'b00, den})
        begin
            q_bit   = 1'b1;
            rem_out = (DEN_W + 1)'(shifted - {2'b00, den});
        end
        else
        begin
            q_bit   = 1'b0;
            rem_out = shifted[DEN_W:0];
        end
    end

endmodule

FILE: rtl/two_body_acceleration.sv
// ----------------------------------------------------------------------------
// two_body_acceleration: state derivative with two-body gravity, Q-format out
// Sum of squares, pipelined isqrt, cube, mu*|p| product and a pipelined
// restoring divider per axis; saturation and sign on the last stage.
// ----------------------------------------------------------------------------
// Pipeline: 1 + 1 + 16 + 1 + 1 + NUM_W + 1 register stages (127 at
//   ACCEL_FRAC_BITS = 24). Throughput one beat per cycle, the whole pipe
//   advances together and holds in place on output backpressure.
// Cycle time is set by the per-stage compare-subtract of the divider and isqrt.
// Reset: valid bits clear, gravity_param returns to 398717000000000.
module two_body_acceleration
    import tba_pkg::*;
#(
    parameter int ACCEL_FRAC_BITS = 24
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [63:0]  cfg_wdata,      // gravity_param in [49:0]
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,   // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [199:0] m_axis_tdata    // dpos_x..z, accel_x..z, zero_radius,
                                         // saturated, 6 zero pad bits
);

    localparam int MAG_W  = COMP_W;
    localparam int NUM_W  = GP_W + MAG_W + ACCEL_FRAC_BITS;
    localparam int SQ_ST  = ROOT_W / 2;
    localparam int PRE    = 1 + SQ_ST + 1 + 1 + 1;   // into divider
    localparam int DIVS   = NUM_W;
    localparam int DEPTH  = PRE + DIVS + 1;

    logic [GP_W-1:0] gp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gp_reg <= GP_RESET;
        else if (cfg_we)
            gp_reg <= cfg_wdata[GP_W-1:0];
    end

    // whole pipe advances unless the last stage is full and stalled
    logic adv;
    logic [DEPTH-1:0] vld_reg;
    assign adv           = !vld_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
    end

    // stage 0: magnitudes and squares
    logic [MAG_W-1:0] mag_next [3];
    logic [MAG_W-1:0] mag_reg  [3];
    logic [2*MAG_W-1:0] sq_reg [3];
    tba_side_t side_next;
    tba_side_t side_reg [DEPTH];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            side_next.neg[i] = s_axis_tdata[i*COMP_W + COMP_W-1];
            mag_next[i] = side_next.neg[i] ? MAG_W'(-s_axis_tdata[i*COMP_W +: COMP_W])
                                           : s_axis_tdata[i*COMP_W +: COMP_W];
        end
        side_next.vel_x = s_axis_tdata[3*COMP_W +: COMP_W];
        side_next.vel_y = s_axis_tdata[4*COMP_W +: COMP_W];
        side_next.vel_z = s_axis_tdata[5*COMP_W +: COMP_W];
        side_next.zero  = (s_axis_tdata[3*COMP_W-1:0] == '0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int i = 0; i < 3; i++)
            begin
                mag_reg[i] <= mag_next[i];
                sq_reg[i]  <= mag_next[i] * mag_next[i];
            end
            for (int s = 1; s < DEPTH; s++)
                side_reg[s] <= side_reg[s-1];
        end
    end

    // magnitudes travel alongside up to the partial products
    logic [MAG_W-1:0] magd_reg [SQ_ST][3];
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            magd_reg[0] <= mag_reg;
            for (int s = 1; s < SQ_ST; s++)
                magd_reg[s] <= magd_reg[s-1];
        end
    end

    // isqrt pipeline, stage 0 of it forms the sum
    logic [SUMSQ_W-1:0] srem_reg  [SQ_ST+1];
    logic [ROOT_W-1:0]  sroot_reg [SQ_ST+1];
    logic [SUMSQ_W-1:0] srem_next [SQ_ST];
    logic [ROOT_W-1:0]  sroot_next[SQ_ST];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            srem_reg[0]  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sroot_reg[0] <= '0;
            for (int s = 0; s < SQ_ST; s++)
            begin
                srem_reg[s+1]  <= srem_next[s];
                sroot_reg[s+1] <= sroot_next[s];
            end
        end
    end

    for (genvar g = 0; g < SQ_ST; g++)
    begin : g_sqrt
        tba_sqrt_stage #(.STEP(g)) u_sq (
            .rem_in  (srem_reg[g]),
            .root_in (sroot_reg[g]),
            .rem_out (srem_next[g]),
            .root_out(sroot_next[g])
        );
    end

    // r^2, then r^3; mu*|p| split into two partial products, then summed
    logic [2*ROOT_W-1:0] r2_reg;
    logic [ROOT_W-1:0]   r1_reg;
    logic [DEN_W-1:0]    den_reg [DIVS+1];
    logic [2*MAG_W-1:0]  pp_lo_reg [3];
    logic [GP_W-1:0]     pp_hi_reg [3];
    logic [GP_W+MAG_W-1:0] prod_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                // mu[31:0]*|p| and mu[49:32]*|p|, alongside the last isqrt step
                pp_lo_reg[i] <= 64'(gp_reg[31:0]) * 64'(magd_reg[SQ_ST-1][i]);
                pp_hi_reg[i] <= GP_W'(gp_reg[GP_W-1:32]) * GP_W'(magd_reg[SQ_ST-1][i]);
                prod_reg[i]  <= (GP_W+MAG_W)'(pp_lo_reg[i])
                              + ((GP_W+MAG_W)'(pp_hi_reg[i]) << 32);
            end
            r2_reg <= sroot_reg[SQ_ST] * sroot_reg[SQ_ST];
            r1_reg <= sroot_reg[SQ_ST];
            // r^2 is 64 bits: split into two 32x32 products summed
            den_reg[0] <= DEN_W'(64'(r2_reg[31:0]) * 64'(r1_reg))
                        + (DEN_W'(64'(r2_reg[63:32]) * 64'(r1_reg)) << 32);
            for (int s = 1; s <= DIVS; s++)
                den_reg[s] <= den_reg[s-1];
        end
    end

    // divider: NUM_W restoring stages per axis
    logic [NUM_W-1:0] num_reg [DIVS+1][3];
    logic [DEN_W:0]   drem_reg [DIVS+1][3];
    logic [NUM_W-1:0] q_reg   [DIVS+1][3];
    logic [DEN_W:0]   drem_next [DIVS][3];
    logic             qb_next   [DIVS][3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[0][i]  <= {prod_reg[i], {ACCEL_FRAC_BITS{1'b0}}};
                drem_reg[0][i] <= '0;
                q_reg[0][i]    <= '0;
                for (int s = 0; s < DIVS; s++)
                begin
                    num_reg[s+1][i]  <= num_reg[s][i];
                    drem_reg[s+1][i] <= drem_next[s][i];
                    q_reg[s+1][i]    <= {q_reg[s][i][NUM_W-2:0], qb_next[s][i]};
                end
            end
        end
    end

    for (genvar s = 0; s < DIVS; s++)
    begin : g_div
        for (genvar i = 0; i < 3; i++)
        begin : g_ax
            tba_div_stage u_dv (
                .rem_in (drem_reg[s][i]),
                .num_bit(num_reg[s][i][NUM_W-1-s]),
                .den    (den_reg[s]),
                .rem_out(drem_next[s][i]),
                .q_bit  (qb_next[s][i])
            );
        end
    end

    // output stage: saturate, sign, zero radius
    logic [COMP_W-1:0] acc_next [3];
    logic [2:0]        sat_next;
    logic [199:0]      out_reg;
    tba_side_t         fs;

    always_comb
    begin
        fs = side_reg[DEPTH-2];
        for (int i = 0; i < 3; i++)
        begin
            logic [NUM_W-1:0] lim;
            logic [NUM_W-1:0] m;
            lim = fs.neg[i] ? NUM_W'(32'h7FFF_FFFF) : NUM_W'(33'h8000_0000);
            m   = q_reg[DIVS][i];
            sat_next[i] = 1'b0;
            if (m > lim)
            begin
                m = lim;
                sat_next[i] = 1'b1;
            end
            acc_next[i] = fs.neg[i] ? m[COMP_W-1:0] : COMP_W'(-m[COMP_W-1:0]);
            if (fs.zero)
            begin
                acc_next[i] = '0;
                sat_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= {6'd0, |sat_next, fs.zero, acc_next[2], acc_next[1], acc_next[0],
                        fs.vel_z, fs.vel_y, fs.vel_x};
    end

    assign m_axis_tdata = out_reg;

    a_zero_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[192] |-> !m_axis_tdata[193])
        else $error("zero radius with saturation");
    a_zero_acc: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[192] |-> m_axis_tdata[191:96] == '0)
        else $error("zero radius with nonzero acceleration");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output lost under stall");

endmodule
